>>> hdl/sem_pkg.sv
// shared types and constants for the rgb sobel edge magnitude block
package sem_pkg;

  localparam int MaxWidth = 1024;
  localparam int ColW     = $clog2(MaxWidth);
  localparam int PixW     = 24;
  localparam int Lanes    = 4;
  localparam int LaneW    = $clog2(Lanes);
  localparam int WidthW   = 11;
  localparam int HeightW  = 12;
  localparam int CountW   = 22;
  localparam int SumW     = 21;
  localparam int ChanN    = 3;
  localparam int MagW     = 8;
  localparam int CfgW     = 12;

  localparam logic [WidthW-1:0]  WidthReset  = 11'd640;
  localparam logic [HeightW-1:0] HeightReset = 12'd480;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } sem_reg_t;

  typedef logic [SumW-1:0] sem_sum_t;
  typedef logic [MagW-1:0] sem_mag_t;

  typedef struct packed {
    logic       func;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } sem_in_t;

  typedef struct packed {
    logic [7:0] edge_red;
    logic [7:0] edge_green;
    logic [7:0] edge_blue;
    logic       frame_end;
  } sem_out_t;

endpackage

>>> hdl/sem_root.sv
// iterative rounded square root for three channels, one result bit per cycle
module sem_root (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  sem_pkg::sem_sum_t [sem_pkg::ChanN-1:0] sq,
  output logic                                 done,
  output sem_pkg::sem_mag_t [sem_pkg::ChanN-1:0] mag
);
  import sem_pkg::*;

  logic [MagW-1:0]  probe;
  logic             busy;
  sem_mag_t [ChanN-1:0] trial;
  logic [ChanN-1:0] keep;
  logic [2*MagW-1:0] prod [ChanN];

  always_comb begin
    for (int ch = 0; ch < ChanN; ch++) begin
      trial[ch] = mag[ch] | probe;
      prod[ch]  = (2*MagW)'(trial[ch]) * (2*MagW)'(trial[ch] - MagW'(1));
      keep[ch]  = SumW'(prod[ch]) < sq[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      probe <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        probe <= {1'b1, {(MagW-1){1'b0}}};
        mag   <= '0;
      end else if (busy) begin
        for (int ch = 0; ch < ChanN; ch++) begin
          if (keep[ch]) begin
            mag[ch] <= trial[ch];
          end
        end
        probe <= probe >> 1;
        if (probe[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hdl/sobel_edge_magnitude_rgb.sv
// top level: streaming 3x3 sobel edge magnitude on rgb pixels
// One pixel is taken per handshake in raster order; the result for raster position p
// leaves after pixel p+width+1 is taken, and width+1 drain ticks after the last pixel
// flush the frame. An item that yields a result keeps the input stalled while the
// block reads the row store (one read per window column plus the read latency), forms
// the squared sum, runs the bit-serial root unit (start, eight result bits, done) and
// hands the result to the output register, which waits out any output stall. An item
// without a result does not stall the input. Writing frame_width or frame_height
// abandons the frame in progress. The row store holds four rows of 1024 pixels and
// needs no clearing after reset.
module sobel_edge_magnitude_rgb (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pix_valid,
  output logic                         pix_stall,
  input  sem_pkg::sem_in_t             pix_data,
  output logic                         mag_valid,
  input  logic                         mag_stall,
  output sem_pkg::sem_out_t            mag_data,
  input  logic                         cfg_we,
  input  sem_pkg::sem_reg_t            cfg_index,
  input  logic [sem_pkg::CfgW-1:0]     cfg_data
);
  import sem_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_SUM  = 5'b00100,
    ST_ROOT = 5'b01000,
    ST_PUSH = 5'b10000
  } state_t;

  state_t state;

  logic [WidthW-1:0]  frame_width;
  logic [HeightW-1:0] frame_height;
  logic [WidthW-1:0]  w_eff;
  logic [HeightW-1:0] h_eff;

  logic [ColW-1:0]    col;
  logic [HeightW:0]   row;
  logic [CountW-1:0]  emitted;
  logic               draining;

  logic [Lanes*PixW-1:0] row_mem [MaxWidth];
  logic [Lanes*PixW-1:0] rd_data;
  logic [ColW-1:0]       rd_addr;

  logic               accept;
  logic               proc;
  logic               emit;
  logic               last;
  logic               fend;
  logic [WidthW+HeightW-1:0] total;
  logic [WidthW-1:0]  col_next;
  logic [HeightW-1:0] pr_n;
  logic [ColW-1:0]    pc_n;

  logic [HeightW-1:0] pr;
  logic [ColW-1:0]    pc;
  logic               fend_hold;
  logic [1:0]         rd_step;
  logic [1:0]         j;
  logic               col_ok;
  logic [2:0]         row_ok;
  logic [LaneW-1:0]   lane [3];
  logic [HeightW:0]   pr_up;

  logic signed [11:0] gx [ChanN];
  logic signed [11:0] gy [ChanN];
  logic signed [11:0] gx_next [ChanN];
  logic signed [11:0] gy_next [ChanN];
  logic [7:0]         pa [ChanN];
  logic [7:0]         pb [ChanN];
  logic [7:0]         pcc [ChanN];
  logic [9:0]         vsum [ChanN];
  logic signed [11:0] dif [ChanN];

  sem_sum_t [ChanN-1:0] sq;
  sem_mag_t [ChanN-1:0] mag;
  logic                 root_start;
  logic                 root_done;
  logic                 out_free;

  assign w_eff = (frame_width == '0) ? WidthW'(1) :
                 (frame_width > WidthW'(MaxWidth)) ? WidthW'(MaxWidth) : frame_width;
  assign h_eff = (frame_height == '0) ? HeightW'(1) : frame_height;

  assign pix_stall = (state != ST_IDLE);
  assign accept    = pix_valid && !pix_stall;
  assign proc      = draining || (pix_data.func == FUNC_PIXEL);
  assign emit      = (row >= (HeightW+1)'(2)) || (row == (HeightW+1)'(1) && col != '0);
  assign last      = !draining && (row == {1'b0, h_eff} - (HeightW+1)'(1)) &&
                     ({1'b0, col} == w_eff - WidthW'(1));
  assign total     = (WidthW+HeightW)'(w_eff) * (WidthW+HeightW)'(h_eff);
  assign fend      = emit && ((WidthW+HeightW)'(emitted) ==
                              total - (WidthW+HeightW)'(1));
  assign col_next  = {1'b0, col} + WidthW'(1);
  assign pr_n      = (col != '0) ? HeightW'(row - (HeightW+1)'(1)) :
                                   HeightW'(row - (HeightW+1)'(2));
  assign pc_n      = (col != '0) ? col - ColW'(1) : ColW'(w_eff - WidthW'(1));
  assign out_free  = !mag_valid || !mag_stall;

  assign rd_addr = pc + ColW'(rd_step) - ColW'(1);
  assign j       = rd_step - 2'd1;
  assign pr_up   = {1'b0, pr} + (HeightW+1)'(1);

  always_comb begin
    unique case (j)
      2'd0:    col_ok = (pc != '0);
      2'd1:    col_ok = 1'b1;
      default: col_ok = ({1'b0, pc} + WidthW'(1)) < w_eff;
    endcase
    row_ok[0] = (pr != '0);
    row_ok[1] = (pr < h_eff);
    row_ok[2] = (pr_up < {1'b0, h_eff});
    lane[0]   = LaneW'(pr - HeightW'(1));
    lane[1]   = LaneW'(pr);
    lane[2]   = LaneW'(pr_up);
    for (int ch = 0; ch < ChanN; ch++) begin
      pa[ch]  = (col_ok && row_ok[0]) ?
                rd_data[lane[0]*PixW + (ChanN-1-ch)*8 +: 8] : 8'd0;
      pb[ch]  = (col_ok && row_ok[1]) ?
                rd_data[lane[1]*PixW + (ChanN-1-ch)*8 +: 8] : 8'd0;
      pcc[ch] = (col_ok && row_ok[2]) ?
                rd_data[lane[2]*PixW + (ChanN-1-ch)*8 +: 8] : 8'd0;
      vsum[ch] = 10'(pa[ch]) + {1'b0, pb[ch], 1'b0} + 10'(pcc[ch]);
      dif[ch]  = $signed({4'd0, pcc[ch]}) - $signed({4'd0, pa[ch]});
      gx_next[ch] = gx[ch];
      gy_next[ch] = gy[ch];
      unique case (j)
        2'd0: begin
          gx_next[ch] = gx[ch] - $signed({2'd0, vsum[ch]});
          gy_next[ch] = gy[ch] + dif[ch];
        end
        2'd1: begin
          gy_next[ch] = gy[ch] + (dif[ch] <<< 1);
        end
        default: begin
          gx_next[ch] = gx[ch] + $signed({2'd0, vsum[ch]});
          gy_next[ch] = gy[ch] + dif[ch];
        end
      endcase
    end
  end

  // row store: one 24-bit lane per row modulo four
  always_ff @(posedge clk) begin
    if (accept && !draining && pix_data.func == FUNC_PIXEL) begin
      row_mem[col][LaneW'(row)*PixW +: PixW] <=
        {pix_data.pixel_red, pix_data.pixel_green, pix_data.pixel_blue};
    end
    rd_data <= row_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      frame_width  <= WidthReset;
      frame_height <= HeightReset;
      col          <= '0;
      row          <= '0;
      emitted      <= '0;
      draining     <= 1'b0;
      rd_step      <= '0;
      root_start   <= 1'b0;
      mag_valid    <= 1'b0;
    end else begin
      root_start <= 1'b0;
      if (mag_valid && !mag_stall) begin
        mag_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WIDTH:  frame_width  <= cfg_data[WidthW-1:0];
          REG_HEIGHT: frame_height <= cfg_data[HeightW-1:0];
          default:    frame_width  <= frame_width;
        endcase
        col      <= '0;
        row      <= '0;
        emitted  <= '0;
        draining <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && proc) begin
            if (col_next >= w_eff) begin
              col <= '0;
              row <= row + (HeightW+1)'(1);
            end else begin
              col <= ColW'(col_next);
            end
            if (emit) begin
              emitted   <= emitted + CountW'(1);
              pr        <= pr_n;
              pc        <= pc_n;
              fend_hold <= fend;
              rd_step   <= '0;
              for (int ch = 0; ch < ChanN; ch++) begin
                gx[ch] <= '0;
                gy[ch] <= '0;
              end
              state <= ST_READ;
            end
            if (last) begin
              draining <= 1'b1;
            end
            if (fend) begin
              col      <= '0;
              row      <= '0;
              emitted  <= '0;
              draining <= 1'b0;
            end
          end
        end
        ST_READ: begin
          rd_step <= rd_step + 2'd1;
          if (rd_step != '0) begin
            for (int ch = 0; ch < ChanN; ch++) begin
              gx[ch] <= gx_next[ch];
              gy[ch] <= gy_next[ch];
            end
          end
          if (rd_step == 2'd3) begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          for (int ch = 0; ch < ChanN; ch++) begin
            sq[ch] <= SumW'(gx[ch] * gx[ch]) + SumW'(gy[ch] * gy[ch]);
          end
          root_start <= 1'b1;
          state      <= ST_ROOT;
        end
        ST_ROOT: begin
          if (root_done) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (out_free) begin
            mag_data  <= '{edge_red: mag[0], edge_green: mag[1], edge_blue: mag[2],
                           frame_end: fend_hold};
            mag_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  sem_root u_root (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .sq    (sq),
    .done  (root_done),
    .mag   (mag)
  );

  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    {1'b0, col} < w_eff)
    else $error("column counter past frame width");

  a_drain_rows: assert property (@(posedge clk) disable iff (rst)
    draining |-> (row >= {1'b0, h_eff} - (HeightW+1)'(1)))
    else $error("draining before the last row");

  a_root_in_state: assert property (@(posedge clk) disable iff (rst)
    root_done |-> (state == ST_ROOT))
    else $error("root result outside root state");

  a_push_then_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PUSH && out_free) |=> mag_valid)
    else $error("result lost on push");

endmodule
